// File: design/scfu_pkg.sv
// ----------------------------------------------------------------------------
// scfu_pkg: shared types, constants and microprogram for the crossfeed filter
// Holds field widths, register indexes, datapath select codes, the control
// word layout and the read-only microprogram that sequences one item.
// ----------------------------------------------------------------------------
package scfu_pkg;

   // Default parameter values
   localparam int NUM_PAIRS_DEF = 4;
   localparam int FRAC_BITS_DEF = 28;

   // Field widths
   localparam int SAMPLE_W = 32;
   localparam int PAIR_W   = 2;
   localparam int GAIN_W   = 29;
   localparam int POLE_W   = 29;
   localparam int COEF_W   = 30;
   localparam int MASK_W   = 4;
   localparam int PROD_W   = COEF_W + SAMPLE_W;

   // Configuration port
   localparam int CSR_DATA_W = 30;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWPASS_POLE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLPASS_COEFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROSSFEED_ON  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_ENABLE   = 3'd4;

   // Multiplier coefficient operand
   localparam logic [1:0] ASEL_GAIN = 2'd0;
   localparam logic [1:0] ASEL_POLE = 2'd1;
   localparam logic [1:0] ASEL_AP   = 2'd2;

   // Multiplier sample operand
   localparam logic [2:0] BSEL_IN_L  = 3'd0;
   localparam logic [2:0] BSEL_IN_R  = 3'd1;
   localparam logic [2:0] BSEL_LPS_L = 3'd2;
   localparam logic [2:0] BSEL_LPS_R = 3'd3;
   localparam logic [2:0] BSEL_LP_L  = 3'd4;
   localparam logic [2:0] BSEL_LP_R  = 3'd5;
   localparam logic [2:0] BSEL_AP_L  = 3'd6;
   localparam logic [2:0] BSEL_AP_R  = 3'd7;

   // Operation applied to the product registered in the previous step
   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_LOAD_T = 4'd1;
   localparam logic [3:0] OP_LP_L   = 4'd2;
   localparam logic [3:0] OP_LP_R   = 4'd3;
   localparam logic [3:0] OP_AP_L   = 4'd4;
   localparam logic [3:0] OP_AP_R   = 4'd5;
   localparam logic [3:0] OP_APS_L  = 4'd6;
   localparam logic [3:0] OP_FINISH = 4'd7;
   localparam logic [3:0] OP_PASS   = 4'd8;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_PASS = 4'd9;

   typedef struct packed {
      logic [1:0]        a_sel;
      logic [2:0]        b_sel;
      logic [3:0]        op;
      logic              jmp_bypass;
      logic [STEP_W-1:0] target;
      logic              done;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      active;
      logic      commit;
   } ctrl_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [POLE_W-1:0] pole;
      logic [COEF_W-1:0] ap_coeff;
      logic              on;
      logic [MASK_W-1:0] mask;
   } cfg_type;

   typedef struct packed {
      logic [PAIR_W-1:0]   pair_index;
      logic [SAMPLE_W-1:0] left_sample;
      logic [SAMPLE_W-1:0] right_sample;
      logic                pair_blocked;
   } item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left_out;
      logic [SAMPLE_W-1:0] right_out;
      logic                applied;
   } result_type;

   localparam ucode_type UCODE_NOP = '{ASEL_GAIN, BSEL_IN_L, OP_NOP, 1'b0, '0, 1'b0};

   // Microprogram. Each step issues one product and applies an operation to
   // the product issued by the step before it. The finishing step reissues
   // the last product so the registered product holds while that step waits.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = UCODE_NOP;
      unique case (step)
         4'd0: w = '{ASEL_GAIN, BSEL_IN_L,  OP_NOP,    1'b1, STEP_PASS, 1'b0};
         4'd1: w = '{ASEL_POLE, BSEL_LPS_L, OP_LOAD_T, 1'b0, '0, 1'b0};
         4'd2: w = '{ASEL_GAIN, BSEL_IN_R,  OP_LP_L,   1'b0, '0, 1'b0};
         4'd3: w = '{ASEL_POLE, BSEL_LPS_R, OP_LOAD_T, 1'b0, '0, 1'b0};
         4'd4: w = '{ASEL_AP,   BSEL_LP_L,  OP_LP_R,   1'b0, '0, 1'b0};
         4'd5: w = '{ASEL_AP,   BSEL_LP_R,  OP_AP_L,   1'b0, '0, 1'b0};
         4'd6: w = '{ASEL_AP,   BSEL_AP_L,  OP_AP_R,   1'b0, '0, 1'b0};
         4'd7: w = '{ASEL_AP,   BSEL_AP_R,  OP_APS_L,  1'b0, '0, 1'b0};
         4'd8: w = '{ASEL_AP,   BSEL_AP_R,  OP_FINISH, 1'b0, '0, 1'b1};
         4'd9: w = '{ASEL_GAIN, BSEL_IN_L,  OP_PASS,   1'b0, '0, 1'b1};
         default: w = '{ASEL_GAIN, BSEL_IN_L, OP_NOP, 1'b0, '0, 1'b1};
      endcase
      return w;
   endfunction

endpackage

// File: design/scfu_if.sv
// ----------------------------------------------------------------------------
// scfu_if: valid/ready channel interfaces for the crossfeed filter
// One interface for the sample-pair request channel and one for the result.
// ----------------------------------------------------------------------------
interface scfu_req_if;
   logic                                valid;
   logic                                ready;
   logic [scfu_pkg::PAIR_W-1:0]         pair_index;
   logic signed [scfu_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [scfu_pkg::SAMPLE_W-1:0] right_sample;
   logic                                pair_blocked;

   modport source (output valid, pair_index, left_sample, right_sample, pair_blocked,
                   input ready);
   modport sink (input valid, pair_index, left_sample, right_sample, pair_blocked,
                 output ready);
endinterface

interface scfu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [scfu_pkg::SAMPLE_W-1:0] left_out;
   logic signed [scfu_pkg::SAMPLE_W-1:0] right_out;
   logic                                applied;

   modport source (output valid, left_out, right_out, applied, input ready);
   modport sink (input valid, left_out, right_out, applied, output ready);
endinterface

// File: design/scfu_sequencer.sv
// ----------------------------------------------------------------------------
// scfu_sequencer: step counter and microprogram fetch
// Walks the read-only microprogram for one item, takes the bypass jump,
// and holds on a final step while the result register is still full.
// ----------------------------------------------------------------------------
module scfu_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               bypass,
   input  logic               hold,
   output scfu_pkg::ctrl_type ctrl,
   output logic               busy
);

   logic                          busy_ff, busy_in;
   logic [scfu_pkg::STEP_W-1:0]   step_ff, step_in;
   scfu_pkg::ucode_type           word;
   logic                          advance;

   always_comb begin
      word    = scfu_pkg::ucode_rom(step_ff);
      advance = busy_ff && !(word.done && hold);
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      priority if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (advance) begin
         priority if (word.jmp_bypass && bypass) begin
            step_in = word.target;
         end else if (word.done) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl.word   = busy_ff ? word : scfu_pkg::UCODE_NOP;
      ctrl.active = busy_ff;
      ctrl.commit = busy_ff && word.done && !hold;
   end

   assign busy = busy_ff;

endmodule

// File: design/scfu_datapath.sv
// ----------------------------------------------------------------------------
// scfu_datapath: shared multiplier, working registers and per-pair state
// One Q-format multiplier with a registered product, an adder stage driven
// by the control word, and the four filter state arrays.
// ----------------------------------------------------------------------------
module scfu_datapath #(
   parameter int NumPairs = scfu_pkg::NUM_PAIRS_DEF,
   parameter int FracBits = scfu_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  scfu_pkg::item_type   item,
   input  scfu_pkg::cfg_type    cfg,
   input  scfu_pkg::ctrl_type   ctrl,
   output logic                 bypass,
   output scfu_pkg::result_type result
);

   localparam int SW    = scfu_pkg::SAMPLE_W;
   localparam int PairW = (NumPairs > 1) ? $clog2(NumPairs) : 1;
   localparam int IdxW  = (PairW > scfu_pkg::PAIR_W) ? PairW : scfu_pkg::PAIR_W;

   scfu_pkg::item_type item_ff;

   logic [SW-1:0] p_ff, t_ff, lpl_ff, lpr_ff, apl_ff, apr_ff;
   logic [SW-1:0] p_in, t_in, lpl_in, lpr_in, apl_in, apr_in;

   logic [SW-1:0] lps_l_ff [NumPairs];
   logic [SW-1:0] lps_r_ff [NumPairs];
   logic [SW-1:0] aps_l_ff [NumPairs];
   logic [SW-1:0] aps_r_ff [NumPairs];

   logic [IdxW-1:0]  pair_wide;
   logic [PairW-1:0] idx;
   logic             pair_ok;

   logic signed [scfu_pkg::COEF_W-1:0] mul_a;
   logic signed [SW-1:0]               mul_b;
   logic signed [scfu_pkg::PROD_W-1:0] prod;

   logic          we_lps_l, we_lps_r, we_aps_l, we_aps_r, clr;
   logic [SW-1:0] aps_l_wdata, aps_r_wdata;

   // Hold the accepted item for the whole program
   always_ff @(posedge clock) begin
      if (start) begin
         item_ff <= item;
      end
   end

   always_comb begin
      pair_wide = IdxW'(item_ff.pair_index);
      idx       = pair_wide[PairW-1:0];
      pair_ok   = int'(item_ff.pair_index) < NumPairs;
      bypass    = !(cfg.on && cfg.mask[item_ff.pair_index] && !item_ff.pair_blocked
                    && pair_ok);
   end

   // Operand select and shared multiplier
   always_comb begin
      unique case (ctrl.word.a_sel)
         scfu_pkg::ASEL_GAIN: mul_a = $signed({1'b0, cfg.gain});
         scfu_pkg::ASEL_POLE: mul_a = $signed({1'b0, cfg.pole});
         scfu_pkg::ASEL_AP:   mul_a = $signed(cfg.ap_coeff);
         default:             mul_a = '0;
      endcase
      unique case (ctrl.word.b_sel)
         scfu_pkg::BSEL_IN_L:  mul_b = $signed(item_ff.left_sample);
         scfu_pkg::BSEL_IN_R:  mul_b = $signed(item_ff.right_sample);
         scfu_pkg::BSEL_LPS_L: mul_b = $signed(lps_l_ff[idx]);
         scfu_pkg::BSEL_LPS_R: mul_b = $signed(lps_r_ff[idx]);
         scfu_pkg::BSEL_LP_L:  mul_b = $signed(lpl_ff);
         scfu_pkg::BSEL_LP_R:  mul_b = $signed(lpr_ff);
         scfu_pkg::BSEL_AP_L:  mul_b = $signed(apl_ff);
         scfu_pkg::BSEL_AP_R:  mul_b = $signed(apr_ff);
         default:              mul_b = '0;
      endcase
      prod = scfu_pkg::PROD_W'(mul_a) * scfu_pkg::PROD_W'(mul_b);
      // floor divide by 2^FracBits, keep the low word
      p_in = prod[FracBits+SW-1:FracBits];
   end

   // Adder stage on the product of the previous step
   always_comb begin
      t_in        = t_ff;
      lpl_in      = lpl_ff;
      lpr_in      = lpr_ff;
      apl_in      = apl_ff;
      apr_in      = apr_ff;
      aps_l_wdata = lpl_ff - p_ff;
      aps_r_wdata = lpr_ff - p_ff;
      we_lps_l    = 1'b0;
      we_lps_r    = 1'b0;
      we_aps_l    = 1'b0;
      we_aps_r    = 1'b0;
      clr         = 1'b0;
      unique case (ctrl.word.op)
         scfu_pkg::OP_NOP: begin
            t_in = t_ff;
         end
         scfu_pkg::OP_LOAD_T: begin
            t_in = p_ff;
         end
         scfu_pkg::OP_LP_L: begin
            lpl_in   = t_ff + p_ff;
            we_lps_l = 1'b1;
         end
         scfu_pkg::OP_LP_R: begin
            lpr_in   = t_ff + p_ff;
            we_lps_r = 1'b1;
         end
         scfu_pkg::OP_AP_L: begin
            apl_in = p_ff + aps_l_ff[idx];
         end
         scfu_pkg::OP_AP_R: begin
            apr_in = p_ff + aps_r_ff[idx];
         end
         scfu_pkg::OP_APS_L: begin
            we_aps_l = 1'b1;
         end
         scfu_pkg::OP_FINISH: begin
            we_aps_r = ctrl.commit;
         end
         scfu_pkg::OP_PASS: begin
            clr = ctrl.commit && pair_ok;
         end
         default: begin
            t_in = t_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      t_ff   <= t_in;
      lpl_ff <= lpl_in;
      lpr_ff <= lpr_in;
      apl_ff <= apl_in;
      apr_ff <= apr_in;
   end

   // Per-pair filter state, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumPairs; i++) begin
            lps_l_ff[i] <= '0;
            lps_r_ff[i] <= '0;
            aps_l_ff[i] <= '0;
            aps_r_ff[i] <= '0;
         end
      end else if (clr) begin
         lps_l_ff[idx] <= '0;
         lps_r_ff[idx] <= '0;
         aps_l_ff[idx] <= '0;
         aps_r_ff[idx] <= '0;
      end else begin
         if (we_lps_l) begin
            lps_l_ff[idx] <= lpl_in;
         end
         if (we_lps_r) begin
            lps_r_ff[idx] <= lpr_in;
         end
         if (we_aps_l) begin
            aps_l_ff[idx] <= aps_l_wdata;
         end
         if (we_aps_r) begin
            aps_r_ff[idx] <= aps_r_wdata;
         end
      end
   end

   always_comb begin
      if (ctrl.word.op == scfu_pkg::OP_FINISH) begin
         result.left_out  = item_ff.left_sample - lpl_ff + apr_ff;
         result.right_out = item_ff.right_sample - lpr_ff + apl_ff;
         result.applied   = 1'b1;
      end else begin
         result.left_out  = item_ff.left_sample;
         result.right_out = item_ff.right_sample;
         result.applied   = 1'b0;
      end
   end

endmodule

// File: design/stereo_crossfeed_filter_unit.sv
// ----------------------------------------------------------------------------
// stereo_crossfeed_filter_unit: microcoded stereo crossfeed filter
// Lowpass plus all-pass crossfeed on one stereo sample pair per item, with
// filter state kept per output pair and coefficients shared by all pairs.
//
//   Channel   Dir   Handshake          Carries
//   req_chan  in    valid/ready        pair_index, left/right sample, blocked
//   rsp_chan  out   valid/ready        left_out, right_out, applied
//   csr_*     in    write enable only  index, data (no read-back)
//
// A crossfeed item runs nine microprogram steps on one shared multiplier
// (eight products and a finishing add); a passthrough item skips to the
// pass step. No new item is taken until the current one is done. Reset
// is synchronous and clears the sequencer, the result valid flag, the
// configuration registers and every pair's filter state. A full result
// register stalls the program only on its final step; the next item is
// taken as soon as that step has written the result register.
// ----------------------------------------------------------------------------
module stereo_crossfeed_filter_unit #(
   parameter int NUM_PAIRS = scfu_pkg::NUM_PAIRS_DEF,
   parameter int FRAC_BITS = scfu_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   scfu_req_if.sink                           req_chan,
   scfu_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [scfu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [scfu_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   scfu_pkg::cfg_type    cfg_ff, cfg_in;
   scfu_pkg::item_type   item;
   scfu_pkg::ctrl_type   ctrl;
   scfu_pkg::result_type result, rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 busy, start, bypass, hold;

   // Configuration registers; write them only while the block is idle
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            scfu_pkg::CSR_LOWPASS_GAIN:  cfg_in.gain     = csr_write_data[scfu_pkg::GAIN_W-1:0];
            scfu_pkg::CSR_LOWPASS_POLE:  cfg_in.pole     = csr_write_data[scfu_pkg::POLE_W-1:0];
            scfu_pkg::CSR_ALLPASS_COEFF: cfg_in.ap_coeff = csr_write_data[scfu_pkg::COEF_W-1:0];
            scfu_pkg::CSR_CROSSFEED_ON:  cfg_in.on       = csr_write_data[0];
            scfu_pkg::CSR_PAIR_ENABLE:   cfg_in.mask     = csr_write_data[scfu_pkg::MASK_W-1:0];
            default:                     cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain     <= '0;
         cfg_ff.pole     <= '0;
         // all-pass coefficient resets to one, which passes through
         cfg_ff.ap_coeff <= scfu_pkg::COEF_W'(64'd1 << FRAC_BITS);
         cfg_ff.on       <= 1'b0;
         cfg_ff.mask     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input side: take a new item whenever the sequencer is free
   assign req_chan.ready = !busy;
   assign start          = req_chan.valid && !busy;

   always_comb begin
      item.pair_index   = req_chan.pair_index;
      item.left_sample  = req_chan.left_sample;
      item.right_sample = req_chan.right_sample;
      item.pair_blocked = req_chan.pair_blocked;
   end

   // Stall the final step while an older result is still waiting
   assign hold = rsp_valid_ff && !rsp_chan.ready;

   scfu_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .bypass (bypass),
      .hold   (hold),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   scfu_datapath #(
      .NumPairs (NUM_PAIRS),
      .FracBits (FRAC_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .item   (item),
      .cfg    (cfg_ff),
      .ctrl   (ctrl),
      .bypass (bypass),
      .result (result)
   );

   // Result register: load on commit, drop once the sink takes it
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (ctrl.commit) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.left_out  = rsp_ff.left_out;
   assign rsp_chan.right_out = rsp_ff.right_out;
   assign rsp_chan.applied   = rsp_ff.applied;

endmodule
